/* rtl/ilhalloc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ilhalloc_pkg
// Shared types and codes for the implicit-list heap allocator.
// ----------------------------------------------------------------------------
package ilhalloc_pkg;

   // Tag words and byte offsets are kept at full 32-bit width so that
   // wrapped offsets and corrupted sizes behave exactly as the scheme defines.
   localparam int unsigned OFFS_W = 32;

   typedef logic [OFFS_W-1:0] offs_type;

   // Request kinds
   localparam logic [1:0] KIND_ALLOC  = 2'd0;
   localparam logic [1:0] KIND_FREE   = 2'd1;
   localparam logic [1:0] KIND_REINIT = 2'd2;

   // Response status codes
   localparam logic [1:0] STAT_DONE      = 2'd0;
   localparam logic [1:0] STAT_ZERO_SIZE = 2'd1;
   localparam logic [1:0] STAT_EXHAUSTED = 2'd2;
   localparam logic [1:0] STAT_BAD_ADDR  = 2'd3;

   // Reset value of the chunk size register
   localparam logic [15:0] CHUNK_RESET = 16'd4096;

   typedef enum logic [4:0] {
      ST_INIT0,
      ST_INIT1,
      ST_INIT2,
      ST_IDLE,
      ST_WALK,
      ST_WEVAL,
      ST_GROW_CHK,
      ST_GROW_W0,
      ST_GROW_W1,
      ST_GROW_W2,
      ST_FREE_RD,
      ST_FREE_W0,
      ST_FREE_W1,
      ST_MRG_R1,
      ST_MRG_R2,
      ST_MRG_R3,
      ST_MRG_R4,
      ST_MRG_DEC,
      ST_MRG_WA,
      ST_MRG_WB,
      ST_MRG_END,
      ST_PUT_HD,
      ST_PUT_FT,
      ST_PUT_SHD,
      ST_PUT_SFT,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

/* rtl/implicit_list_heap_allocator.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// implicit_list_heap_allocator
// First-fit heap allocator over an implicit block list with boundary tags.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. busy stays high
// through the one-cycle response strobe rsp_valid and drops the cycle after.
// The strobe cannot be stalled. All tag words live in one memory with one read
// port and one write port and a registered read. Each port makes one access per
// cycle, and that sets the timing:
// - Allocate: the first-fit walk reads the header of each block it visits and
//   then evaluates it; a walk that runs past the break skips the evaluation.
//   Placing the block writes its header and footer, and the remainder's when
//   one is split off. When the heap must grow, the new block's tags and the
//   epilogue are written and the block is merged with a free neighbor.
// - Free: clears the alloc bit in header and footer, then merges likewise.
// - Reinitialize: rewrites the prologue and epilogue tags.
// - Zero-size request, free outside the heap or unused code: no memory access.
// After reset the block is busy while it writes the prologue and epilogue
// tags. The growth size register may be written any time the block is idle.
// ----------------------------------------------------------------------------
module implicit_list_heap_allocator #(
   parameter int unsigned HEAP_WORDS = 4096,
   parameter int unsigned WORD_BYTES = 8
) (
   input  wire         clock,
   input  wire         reset,
   // request channel
   input  wire         start,
   output logic        busy,
   input  wire  [1:0]  req_type,
   input  wire  [15:0] req_request_size,
   input  wire  [14:0] req_block_addr,
   // response channel
   output logic        rsp_valid,
   output logic [14:0] rsp_payload_addr,
   output logic [1:0]  rsp_status,
   // configuration
   input  wire         csr_wr_en,
   input  wire  [15:0] csr_wr_data
);

   localparam int unsigned AW  = $clog2(HEAP_WORDS);
   localparam int unsigned WSH = $clog2(WORD_BYTES);
   localparam int unsigned NW  = AW + 1;

   localparam ilhalloc_pkg::offs_type WB    = ilhalloc_pkg::offs_type'(WORD_BYTES);
   localparam ilhalloc_pkg::offs_type DBL   = ilhalloc_pkg::offs_type'(2 * WORD_BYTES);
   localparam ilhalloc_pkg::offs_type QUAD  = ilhalloc_pkg::offs_type'(4 * WORD_BYTES);
   localparam ilhalloc_pkg::offs_type BRK0  = ilhalloc_pkg::offs_type'(3 * WORD_BYTES);
   localparam ilhalloc_pkg::offs_type HBYTE =
      ilhalloc_pkg::offs_type'(HEAP_WORDS * WORD_BYTES);
   localparam ilhalloc_pkg::offs_type MASK8 = ~ilhalloc_pkg::offs_type'(7);
   localparam logic [NW-1:0]          NLIM  = NW'(HEAP_WORDS);

   // tag word index of a byte offset
   function automatic logic [AW-1:0] widx(input ilhalloc_pkg::offs_type p);
      return p[WSH +: AW];
   endfunction

   // ---------------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------------
   ilhalloc_pkg::state_type state_ff, state_in;
   logic                    init_rsp_ff, init_rsp_in;
   logic                    is_alloc_ff, is_alloc_in;
   logic [15:0]             chunk_ff;
   ilhalloc_pkg::offs_type  brk_ff, brk_in;
   ilhalloc_pkg::offs_type  need_ff, need_in;
   ilhalloc_pkg::offs_type  bp_ff, bp_in;
   logic [NW-1:0]           n_ff, n_in;
   ilhalloc_pkg::offs_type  sz_ff, sz_in;
   ilhalloc_pkg::offs_type  pft_ff, pft_in;
   ilhalloc_pkg::offs_type  pv_ff, pv_in;
   ilhalloc_pkg::offs_type  nx_ff, nx_in;
   ilhalloc_pkg::offs_type  pvh_ff, pvh_in;
   ilhalloc_pkg::offs_type  have_ff, have_in;
   ilhalloc_pkg::offs_type  grow_ff, grow_in;
   ilhalloc_pkg::offs_type  sz2_ff, sz2_in;
   ilhalloc_pkg::offs_type  ret_ff, ret_in;
   ilhalloc_pkg::offs_type  wa_ff, wa_in;
   ilhalloc_pkg::offs_type  bbase_ff, bbase_in;
   ilhalloc_pkg::offs_type  balt_ff, balt_in;
   logic                    balias_ff, balias_in;
   logic                    split_ff, split_in;
   ilhalloc_pkg::offs_type  diff_ff, diff_in;
   logic [14:0]             pay_ff, pay_in;
   logic [1:0]              stat_ff, stat_in;

   // memory ports
   logic                    mem_we;
   logic [AW-1:0]           mem_waddr;
   ilhalloc_pkg::offs_type  mem_wdata;
   logic [AW-1:0]           mem_raddr;
   ilhalloc_pkg::offs_type  mem_rdata;

   ilhalloc_tag_ram #(
      .DEPTH (HEAP_WORDS)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // ---------------------------------------------------------------------
   // shared conditions
   // ---------------------------------------------------------------------
   logic                   accept;
   ilhalloc_pkg::offs_type req_need;
   ilhalloc_pkg::offs_type addr_ext;
   ilhalloc_pkg::offs_type rd_size;
   logic                   past_brk;
   logic                   walk_fit;
   ilhalloc_pkg::offs_type walk_next;
   ilhalloc_pkg::offs_type chunk_r8;
   ilhalloc_pkg::offs_type grow_c;
   logic                   grow_fail;
   logic                   pu, nu;

   assign accept    = start && (state_ff == ilhalloc_pkg::ST_IDLE);
   assign req_need  = (ilhalloc_pkg::offs_type'(req_request_size) + DBL +
                       ilhalloc_pkg::offs_type'(7)) & MASK8;
   assign addr_ext  = ilhalloc_pkg::offs_type'(req_block_addr);
   assign rd_size   = mem_rdata & MASK8;
   assign past_brk  = (bp_ff - WB) >= brk_ff;
   assign walk_fit  = !mem_rdata[0] && (need_ff <= rd_size);
   assign walk_next = bp_ff + rd_size;
   assign chunk_r8  = (ilhalloc_pkg::offs_type'(chunk_ff) + ilhalloc_pkg::offs_type'(7))
                      & MASK8;
   assign grow_c    = (need_ff > chunk_r8) ? need_ff : chunk_r8;
   assign grow_fail = grow_c > (HBYTE - brk_ff);
   assign pu        = pvh_ff[0];
   assign nu        = mem_rdata[0];

   // ---------------------------------------------------------------------
   // next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ilhalloc_pkg::ST_INIT0: state_in = ilhalloc_pkg::ST_INIT1;
         ilhalloc_pkg::ST_INIT1: state_in = ilhalloc_pkg::ST_INIT2;
         ilhalloc_pkg::ST_INIT2: begin
            state_in = init_rsp_ff ? ilhalloc_pkg::ST_DONE : ilhalloc_pkg::ST_IDLE;
         end
         ilhalloc_pkg::ST_IDLE: begin
            if (start) begin
               unique case (req_type)
                  ilhalloc_pkg::KIND_ALLOC: begin
                     state_in = (req_request_size == 16'd0) ? ilhalloc_pkg::ST_DONE
                                                            : ilhalloc_pkg::ST_WALK;
                  end
                  ilhalloc_pkg::KIND_FREE: begin
                     state_in = (addr_ext >= brk_ff) ? ilhalloc_pkg::ST_DONE
                                                     : ilhalloc_pkg::ST_FREE_RD;
                  end
                  ilhalloc_pkg::KIND_REINIT: state_in = ilhalloc_pkg::ST_INIT0;
                  default:                   state_in = ilhalloc_pkg::ST_DONE;
               endcase
            end
         end
         ilhalloc_pkg::ST_WALK: begin
            state_in = past_brk ? ilhalloc_pkg::ST_GROW_CHK : ilhalloc_pkg::ST_WEVAL;
         end
         ilhalloc_pkg::ST_WEVAL: begin
            priority if (rd_size == '0) begin
               state_in = ilhalloc_pkg::ST_GROW_CHK;
            end else if (walk_fit) begin
               state_in = ilhalloc_pkg::ST_PUT_HD;
            end else if ((n_ff + NW'(1)) == NLIM) begin
               state_in = ilhalloc_pkg::ST_GROW_CHK;
            end else begin
               state_in = ilhalloc_pkg::ST_WALK;
            end
         end
         ilhalloc_pkg::ST_GROW_CHK: begin
            state_in = grow_fail ? ilhalloc_pkg::ST_DONE : ilhalloc_pkg::ST_GROW_W0;
         end
         ilhalloc_pkg::ST_GROW_W0: state_in = ilhalloc_pkg::ST_GROW_W1;
         ilhalloc_pkg::ST_GROW_W1: state_in = ilhalloc_pkg::ST_GROW_W2;
         ilhalloc_pkg::ST_GROW_W2: state_in = ilhalloc_pkg::ST_MRG_R1;
         ilhalloc_pkg::ST_FREE_RD: state_in = ilhalloc_pkg::ST_FREE_W0;
         ilhalloc_pkg::ST_FREE_W0: state_in = ilhalloc_pkg::ST_FREE_W1;
         ilhalloc_pkg::ST_FREE_W1: state_in = ilhalloc_pkg::ST_MRG_R1;
         ilhalloc_pkg::ST_MRG_R1:  state_in = ilhalloc_pkg::ST_MRG_R2;
         ilhalloc_pkg::ST_MRG_R2:  state_in = ilhalloc_pkg::ST_MRG_R3;
         ilhalloc_pkg::ST_MRG_R3:  state_in = ilhalloc_pkg::ST_MRG_R4;
         ilhalloc_pkg::ST_MRG_R4:  state_in = ilhalloc_pkg::ST_MRG_DEC;
         ilhalloc_pkg::ST_MRG_DEC: begin
            state_in = (pu && nu) ? ilhalloc_pkg::ST_MRG_END : ilhalloc_pkg::ST_MRG_WA;
         end
         ilhalloc_pkg::ST_MRG_WA:  state_in = ilhalloc_pkg::ST_MRG_WB;
         ilhalloc_pkg::ST_MRG_WB:  state_in = ilhalloc_pkg::ST_MRG_END;
         ilhalloc_pkg::ST_MRG_END: begin
            state_in = is_alloc_ff ? ilhalloc_pkg::ST_PUT_HD : ilhalloc_pkg::ST_DONE;
         end
         ilhalloc_pkg::ST_PUT_HD:  state_in = ilhalloc_pkg::ST_PUT_FT;
         ilhalloc_pkg::ST_PUT_FT: begin
            state_in = split_ff ? ilhalloc_pkg::ST_PUT_SHD : ilhalloc_pkg::ST_DONE;
         end
         ilhalloc_pkg::ST_PUT_SHD: state_in = ilhalloc_pkg::ST_PUT_SFT;
         ilhalloc_pkg::ST_PUT_SFT: state_in = ilhalloc_pkg::ST_DONE;
         ilhalloc_pkg::ST_DONE:    state_in = ilhalloc_pkg::ST_IDLE;
         default:                  state_in = ilhalloc_pkg::ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------
   // datapath and memory port control
   // ---------------------------------------------------------------------
   always_comb begin
      init_rsp_in = init_rsp_ff;
      is_alloc_in = is_alloc_ff;
      brk_in      = brk_ff;
      need_in     = need_ff;
      bp_in       = bp_ff;
      n_in        = n_ff;
      sz_in       = sz_ff;
      pft_in      = pft_ff;
      pv_in       = pv_ff;
      nx_in       = nx_ff;
      pvh_in      = pvh_ff;
      have_in     = have_ff;
      grow_in     = grow_ff;
      sz2_in      = sz2_ff;
      ret_in      = ret_ff;
      wa_in       = wa_ff;
      bbase_in    = bbase_ff;
      balt_in     = balt_ff;
      balias_in   = balias_ff;
      split_in    = split_ff;
      diff_in     = diff_ff;
      pay_in      = pay_ff;
      stat_in     = stat_ff;
      mem_we      = 1'b0;
      mem_waddr   = widx(bp_ff - WB);
      mem_wdata   = sz2_ff;
      mem_raddr   = widx(bp_ff - WB);

      unique case (state_ff)
         // prologue and epilogue tags
         ilhalloc_pkg::ST_INIT0: begin
            mem_we    = 1'b1;
            mem_waddr = widx('0);
            mem_wdata = DBL | ilhalloc_pkg::offs_type'(1);
         end
         ilhalloc_pkg::ST_INIT1: begin
            mem_we    = 1'b1;
            mem_waddr = widx(WB);
            mem_wdata = DBL | ilhalloc_pkg::offs_type'(1);
         end
         ilhalloc_pkg::ST_INIT2: begin
            mem_we    = 1'b1;
            mem_waddr = widx(DBL);
            mem_wdata = ilhalloc_pkg::offs_type'(1);
            brk_in    = BRK0;
         end
         // request capture
         ilhalloc_pkg::ST_IDLE: begin
            if (accept) begin
               pay_in      = '0;
               stat_in     = ilhalloc_pkg::STAT_DONE;
               init_rsp_in = (req_type == ilhalloc_pkg::KIND_REINIT);
               is_alloc_in = (req_type == ilhalloc_pkg::KIND_ALLOC);
               need_in     = req_need;
               bp_in       = WB;
               n_in        = '0;
               if ((req_type == ilhalloc_pkg::KIND_ALLOC) && (req_request_size == 16'd0)) begin
                  stat_in = ilhalloc_pkg::STAT_ZERO_SIZE;
               end
               if (req_type == ilhalloc_pkg::KIND_FREE) begin
                  bp_in = addr_ext;
                  if (addr_ext >= brk_ff) begin
                     stat_in = ilhalloc_pkg::STAT_BAD_ADDR;
                  end
               end
            end
         end
         // first-fit walk: read header, then evaluate
         ilhalloc_pkg::ST_WALK: begin
            mem_raddr = widx(bp_ff - WB);
         end
         ilhalloc_pkg::ST_WEVAL: begin
            if (rd_size != '0) begin
               if (walk_fit) begin
                  have_in = rd_size;
               end else begin
                  bp_in = walk_next;
                  n_in  = n_ff + NW'(1);
               end
            end
         end
         // heap growth
         ilhalloc_pkg::ST_GROW_CHK: begin
            grow_in = grow_c;
            bp_in   = brk_ff;
            if (grow_fail) begin
               stat_in = ilhalloc_pkg::STAT_EXHAUSTED;
            end
         end
         ilhalloc_pkg::ST_GROW_W0: begin
            mem_we    = 1'b1;
            mem_waddr = widx(bp_ff - WB);
            mem_wdata = grow_ff;
         end
         ilhalloc_pkg::ST_GROW_W1: begin
            mem_we    = 1'b1;
            mem_waddr = widx(bp_ff + grow_ff - DBL);
            mem_wdata = grow_ff;
         end
         ilhalloc_pkg::ST_GROW_W2: begin
            mem_we    = 1'b1;
            mem_waddr = widx(bp_ff + grow_ff - WB);
            mem_wdata = ilhalloc_pkg::offs_type'(1);
            brk_in    = brk_ff + grow_ff;
         end
         // free: clear alloc bit in header and footer
         ilhalloc_pkg::ST_FREE_RD: begin
            mem_raddr = widx(bp_ff - WB);
         end
         ilhalloc_pkg::ST_FREE_W0: begin
            mem_we    = 1'b1;
            mem_waddr = widx(bp_ff - WB);
            mem_wdata = rd_size;
            sz_in     = rd_size;
         end
         ilhalloc_pkg::ST_FREE_W1: begin
            mem_we    = 1'b1;
            mem_waddr = widx(bp_ff + sz_ff - DBL);
            mem_wdata = sz_ff;
         end
         // merge: gather prev footer, own header, prev and next headers
         ilhalloc_pkg::ST_MRG_R1: begin
            mem_raddr = widx(bp_ff - DBL);
         end
         ilhalloc_pkg::ST_MRG_R2: begin
            pft_in    = rd_size;
            mem_raddr = widx(bp_ff - WB);
         end
         ilhalloc_pkg::ST_MRG_R3: begin
            sz_in     = rd_size;
            pv_in     = bp_ff - pft_ff;
            mem_raddr = widx(bp_ff - pft_ff - WB);
         end
         ilhalloc_pkg::ST_MRG_R4: begin
            pvh_in    = mem_rdata;
            nx_in     = bp_ff + sz_ff;
            mem_raddr = widx(bp_ff + sz_ff - WB);
         end
         ilhalloc_pkg::ST_MRG_DEC: begin
            priority if (pu && nu) begin
               sz2_in = sz_ff;
               ret_in = bp_ff;
            end else if (pu) begin
               sz2_in    = sz_ff + rd_size;
               ret_in    = bp_ff;
               wa_in     = bp_ff - WB;
               bbase_in  = nx_ff;
               balt_in   = rd_size;
               balias_in = widx(nx_ff - WB) == widx(bp_ff - WB);
            end else if (nu) begin
               sz2_in    = sz_ff + (pvh_ff & MASK8);
               ret_in    = pv_ff;
               wa_in     = pv_ff - WB;
               bbase_in  = bp_ff;
               balt_in   = sz_ff;
               balias_in = widx(bp_ff - WB) == widx(pv_ff - WB);
            end else begin
               sz2_in    = sz_ff + (pvh_ff & MASK8) + rd_size;
               ret_in    = pv_ff;
               wa_in     = pv_ff - WB;
               bbase_in  = nx_ff;
               balt_in   = rd_size;
               balias_in = widx(nx_ff - WB) == widx(pv_ff - WB);
            end
         end
         ilhalloc_pkg::ST_MRG_WA: begin
            mem_we    = 1'b1;
            mem_waddr = widx(wa_ff);
            mem_wdata = sz2_ff;
         end
         ilhalloc_pkg::ST_MRG_WB: begin
            mem_we    = 1'b1;
            mem_waddr = widx(bbase_ff + (balias_ff ? sz2_ff : balt_ff) - DBL);
            mem_wdata = sz2_ff;
         end
         ilhalloc_pkg::ST_MRG_END: begin
            bp_in   = ret_ff;
            have_in = sz2_ff;
         end
         // place the block, splitting off a large remainder
         ilhalloc_pkg::ST_PUT_HD: begin
            diff_in   = have_ff - need_ff;
            split_in  = (have_ff - need_ff) >= QUAD;
            pay_in    = bp_ff[14:0];
            mem_we    = 1'b1;
            mem_waddr = widx(bp_ff - WB);
            mem_wdata = (((have_ff - need_ff) >= QUAD) ? need_ff : have_ff)
                        | ilhalloc_pkg::offs_type'(1);
         end
         ilhalloc_pkg::ST_PUT_FT: begin
            mem_we    = 1'b1;
            mem_waddr = widx(bp_ff + (split_ff ? need_ff : have_ff) - DBL);
            mem_wdata = (split_ff ? need_ff : have_ff) | ilhalloc_pkg::offs_type'(1);
            bp_in     = bp_ff + need_ff;
         end
         ilhalloc_pkg::ST_PUT_SHD: begin
            mem_we    = 1'b1;
            mem_waddr = widx(bp_ff - WB);
            mem_wdata = diff_ff;
         end
         ilhalloc_pkg::ST_PUT_SFT: begin
            mem_we    = 1'b1;
            mem_waddr = widx(bp_ff + diff_ff - DBL);
            mem_wdata = diff_ff;
         end
         ilhalloc_pkg::ST_DONE: begin
            init_rsp_in = 1'b0;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // outputs
   // ---------------------------------------------------------------------
   always_comb begin
      busy             = (state_ff != ilhalloc_pkg::ST_IDLE);
      rsp_valid        = (state_ff == ilhalloc_pkg::ST_DONE);
      rsp_payload_addr = pay_ff;
      rsp_status       = stat_ff;
   end

   // ---------------------------------------------------------------------
   // control registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ilhalloc_pkg::ST_INIT0;
         init_rsp_ff <= 1'b0;
         chunk_ff    <= ilhalloc_pkg::CHUNK_RESET;
         brk_ff      <= BRK0;
      end else begin
         state_ff    <= state_in;
         init_rsp_ff <= init_rsp_in;
         brk_ff      <= brk_in;
         if (csr_wr_en) begin
            chunk_ff <= csr_wr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      is_alloc_ff <= is_alloc_in;
      need_ff     <= need_in;
      bp_ff       <= bp_in;
      n_ff        <= n_in;
      sz_ff       <= sz_in;
      pft_ff      <= pft_in;
      pv_ff       <= pv_in;
      nx_ff       <= nx_in;
      pvh_ff      <= pvh_in;
      have_ff     <= have_in;
      grow_ff     <= grow_in;
      sz2_ff      <= sz2_in;
      ret_ff      <= ret_in;
      wa_ff       <= wa_in;
      bbase_ff    <= bbase_in;
      balt_ff     <= balt_in;
      balias_ff   <= balias_in;
      split_ff    <= split_in;
      diff_ff     <= diff_in;
      pay_ff      <= pay_in;
      stat_ff     <= stat_in;
   end

endmodule

`default_nettype wire

/* rtl/ilhalloc_tag_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ilhalloc_tag_ram
// Tag word store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ilhalloc_tag_ram #(
   parameter int unsigned DEPTH = 4096
) (
   input  wire                          clock,
   input  wire                          wr_en,
   input  wire  [$clog2(DEPTH)-1:0]     wr_addr,
   input  wire  ilhalloc_pkg::offs_type wr_data,
   input  wire  [$clog2(DEPTH)-1:0]     rd_addr,
   output ilhalloc_pkg::offs_type       rd_data
);

   ilhalloc_pkg::offs_type mem [DEPTH];
   ilhalloc_pkg::offs_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
